// File: hdl/att_pkg.sv
// Shared types and codes for the allocation tracking table.
package att_pkg;

  typedef struct packed {
    logic [1:0]         operation;
    logic [47:0]        address;
    logic [47:0]        new_address;
    logic [31:0]        alloc_size;
    logic [15:0]        elem_size;
    logic signed [31:0] elem_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [10:0] entry_index;
    logic [10:0] entry_count;
  } out_item_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;
  localparam logic [1:0] OP_BOUNDS  = 2'd3;

  localparam logic [3:0] ST_ADDED       = 4'd0;
  localparam logic [3:0] ST_REUSED      = 4'd1;
  localparam logic [3:0] ST_FREED       = 4'd2;
  localparam logic [3:0] ST_DOUBLE_FREE = 4'd3;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd4;
  localparam logic [3:0] ST_TABLE_FULL  = 4'd5;
  localparam logic [3:0] ST_IN_BOUNDS   = 4'd6;
  localparam logic [3:0] ST_OUT_BOUNDS  = 4'd7;
  localparam logic [3:0] ST_RESIZED     = 4'd8;

  localparam logic [2:0] WR_SHIFT  = 3'd0;
  localparam logic [2:0] WR_FREE   = 3'd1;
  localparam logic [2:0] WR_REUSE  = 3'd2;
  localparam logic [2:0] WR_RESIZE = 3'd3;
  localparam logic [2:0] WR_INSERT = 3'd4;

  typedef struct packed {
    logic       load;
    logic       lk_init;
    logic       key_new;
    logic       lk_read;
    logic       lk_cmp;
    logic       lk_miss;
    logic       rd_en;
    logic       rd_shift;
    logic       wr_en;
    logic [2:0] wr_sel;
    logic       sh_init;
    logic       sh_dec;
    logic       cnt_inc;
    logic       emit;
    logic       use_count;
    logic [3:0] status;
  } att_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       same_addr;
    logic       empty;
    logic       hit;
    logic       found;
    logic       freed;
    logic       full;
    logic       more;
    logic       oob;
  } att_stat_t;

endpackage

// File: hdl/att_datapath.sv
// Datapath of the allocation tracking table: entry memory, search, shift and result registers.
module att_datapath import att_pkg::*; #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int ADDRESS_BITS = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  att_cmd_t  cmd,
  output att_stat_t stat,
  output out_item_t out_item,
  output logic      out_valid
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ADDRESS_BITS + 33;

  logic [EW-1:0] mem [TABLE_DEPTH];

  in_item_t          item_r;
  logic [ADDRESS_BITS-1:0] key_r;
  logic [CW-1:0]     count_r, lo_r, hi_r, pos_r, sh_r;
  logic [AW-1:0]     mid_r;
  logic              found_r;
  logic [EW-1:0]     rd_q_r;
  logic [46:0]       prod_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic [AW-1:0]     mid_w, rd_addr, wr_addr;
  logic [EW-1:0]     wr_data;
  logic [ADDRESS_BITS-1:0] rd_key;
  logic [31:0]       rd_size;
  logic              rd_freed;

  assign rd_key   = rd_q_r[EW-1 -: ADDRESS_BITS];
  assign rd_size  = rd_q_r[32:1];
  assign rd_freed = rd_q_r[0];
  assign mid_w    = AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign rd_addr  = cmd.rd_shift ? AW'(sh_r - CW'(1)) : mid_w;
  assign wr_addr  = (cmd.wr_sel == WR_SHIFT) ? AW'(sh_r) : AW'(pos_r);

  always_comb begin
    case (cmd.wr_sel)
      WR_FREE:   wr_data = {rd_key, rd_size, 1'b1};
      WR_REUSE:  wr_data = {rd_key, item_r.alloc_size, 1'b0};
      WR_RESIZE: wr_data = {rd_key, item_r.alloc_size, rd_freed};
      WR_INSERT: wr_data = {key_r, item_r.alloc_size, 1'b0};
      default:   wr_data = rd_q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    prod_r <= 47'(item_r.elem_size) * 47'(item_r.elem_index[30:0]);
    if (cmd.lk_init) begin
      key_r <= cmd.key_new ? ADDRESS_BITS'(item_r.new_address)
                           : ADDRESS_BITS'(item_r.address);
      lo_r  <= '0;
      hi_r  <= count_r;
    end
    if (cmd.lk_read) begin
      mid_r <= mid_w;
    end
    if (cmd.lk_cmp) begin
      if (rd_key == key_r) begin
        pos_r <= CW'(mid_r);
      end else if (rd_key < key_r) begin
        lo_r <= CW'(mid_r) + CW'(1);
      end else begin
        hi_r <= CW'(mid_r);
      end
    end
    if (cmd.lk_miss) begin
      pos_r <= lo_r;
    end
    if (cmd.sh_init) begin
      sh_r <= count_r;
    end else if (cmd.sh_dec) begin
      sh_r <= sh_r - CW'(1);
    end
    if (cmd.emit) begin
      out_r.status      <= cmd.status;
      out_r.entry_index <= 11'(cmd.use_count ? count_r : pos_r);
      out_r.entry_count <= 11'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.lk_init) begin
        found_r <= 1'b0;
      end else if (cmd.lk_cmp && (rd_key == key_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.op        = item_r.operation;
    stat.same_addr = ADDRESS_BITS'(item_r.address) == ADDRESS_BITS'(item_r.new_address);
    stat.empty     = lo_r >= hi_r;
    stat.hit       = rd_key == key_r;
    stat.found     = found_r;
    stat.freed     = rd_freed;
    stat.full      = count_r == CW'(TABLE_DEPTH);
    stat.more      = sh_r > pos_r;
    stat.oob       = item_r.elem_index[31] || (prod_r > 47'(rd_size));
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  // The fill count can never pass the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // An insert is never issued into a full table.
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (count_r != CW'(TABLE_DEPTH)))
    else $error("insert into full table");

  // A search probe is only issued while the window is open.
  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lk_read |-> (lo_r < hi_r))
    else $error("search probe with empty window");

endmodule

// File: hdl/att_controller.sv
// Controller state machine of the allocation tracking table.
module att_controller import att_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  att_stat_t stat,
  output att_cmd_t  cmd,
  output logic      busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_LK_CHK = 4'd2;
  localparam logic [3:0] S_LK_CMP = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SH_RD  = 4'd5;
  localparam logic [3:0] S_SH_WR  = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic [3:0] st_r, st_nxt;
  logic       uc_r, uc_nxt;
  logic       alloc_mode;

  assign alloc_mode = (stat.op == OP_ALLOC) || ((stat.op == OP_REALLOC) && phase_r);
  assign busy = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    st_nxt    = st_r;
    uc_nxt    = uc_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.lk_init = 1'b1;
        phase_nxt   = 1'b0;
        state_nxt   = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (stat.empty) begin
          cmd.lk_miss = 1'b1;
          state_nxt   = S_DECIDE;
        end else begin
          cmd.lk_read = 1'b1;
          cmd.rd_en   = 1'b1;
          state_nxt   = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        cmd.lk_cmp = 1'b1;
        state_nxt  = stat.hit ? S_DECIDE : S_LK_CHK;
      end
      S_DECIDE: begin
        state_nxt = S_EMIT;
        uc_nxt    = !stat.found;
        st_nxt    = ST_NOT_FOUND;
        if (alloc_mode) begin
          if (stat.found) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REUSE;
            st_nxt     = ST_REUSED;
          end else if (stat.full) begin
            st_nxt = ST_TABLE_FULL;
          end else begin
            cmd.sh_init = 1'b1;
            state_nxt   = S_SH_RD;
          end
        end else begin
          case (stat.op)
            OP_FREE: begin
              if (stat.found) begin
                if (stat.freed) begin
                  st_nxt = ST_DOUBLE_FREE;
                end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_FREE;
                  st_nxt     = ST_FREED;
                end
              end
            end
            OP_REALLOC: begin
              if (stat.same_addr) begin
                if (stat.found) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_RESIZE;
                  st_nxt     = ST_RESIZED;
                end
              end else begin
                // Moving realloc: retire the old entry, then look up the new address.
                cmd.wr_en   = stat.found;
                cmd.wr_sel  = WR_FREE;
                cmd.lk_init = 1'b1;
                cmd.key_new = 1'b1;
                phase_nxt   = 1'b1;
                state_nxt   = S_LK_CHK;
              end
            end
            default: begin
              if (stat.found) begin
                st_nxt = stat.oob ? ST_OUT_BOUNDS : ST_IN_BOUNDS;
              end
            end
          endcase
        end
      end
      S_SH_RD: begin
        if (stat.more) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SH_WR;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.sh_dec = 1'b1;
        state_nxt  = S_SH_RD;
      end
      S_INS: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_INSERT;
        cmd.cnt_inc = 1'b1;
        st_nxt      = ST_ADDED;
        uc_nxt      = 1'b0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.status    = st_r;
        cmd.use_count = uc_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
      st_r    <= ST_ADDED;
      uc_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      st_r    <= st_nxt;
      uc_r    <= uc_nxt;
    end
  end

endmodule

// File: hdl/allocation_tracking_table.sv
// Top level of the allocation tracking table: controller and datapath.
// Each item is loaded, then looked up by binary search over the sorted entries (up to
// log2(depth)+1 probes, each a read and a compare); a miss gives the insert position. A moving
// realloc retires the old entry and runs a second search; an insert shifts entries up, then writes.
// One item is in flight at a time; busy drops in the result cycle, which sets throughput.
// The receiver cannot stall. Synchronous reset empties the table; entry storage is not cleared.
module allocation_tracking_table import att_pkg::*; #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int ADDRESS_BITS = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_valid
);

  att_cmd_t  cmd;
  att_stat_t stat;

  att_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  att_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule

// File: tb/allocation_tracking_table_test.sv
// Testbench for the allocation tracking table: directed table plus random traffic.
`timescale 1ns / 100ps

module allocation_tracking_table_test;
  import att_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 20000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  allocation_tracking_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_item(out_item), .out_valid(out_valid)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Shadow copy of the sorted table.
  logic [47:0] tbl_addr [DEPTH];
  logic [31:0] tbl_size [DEPTH];
  logic        tbl_freed [DEPTH];
  int          tbl_used;
  logic [47:0] live_addrs [$];

  out_item_t pending_results [$];
  int  mismatches;
  int  cycles;
  int  sender_idle_pct;

  function automatic bit find_entry(input logic [47:0] key, output int pos);
    int below;
    below = 0;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_addr[i] == key) begin
        pos = i;
        return 1'b1;
      end
      if (tbl_addr[i] < key) below++;
    end
    pos = below;
    return 1'b0;
  endfunction

  function automatic logic [3:0] track_alloc(input logic [47:0] key, input logic [31:0] sz,
                                             output int idx);
    int pos;
    if (find_entry(key, pos)) begin
      tbl_freed[pos] = 1'b0;
      tbl_size[pos] = sz;
      idx = pos;
      return ST_REUSED;
    end
    if (tbl_used >= DEPTH) begin
      idx = tbl_used;
      return ST_TABLE_FULL;
    end
    for (int i = tbl_used; i > pos; i--) begin
      tbl_addr[i] = tbl_addr[i-1];
      tbl_size[i] = tbl_size[i-1];
      tbl_freed[i] = tbl_freed[i-1];
    end
    tbl_addr[pos] = key;
    tbl_size[pos] = sz;
    tbl_freed[pos] = 1'b0;
    tbl_used++;
    live_addrs.push_back(key);
    idx = pos;
    return ST_ADDED;
  endfunction

  function automatic out_item_t track_item(input in_item_t it);
    out_item_t r;
    int pos;
    int idx;
    logic [3:0] st;
    logic [47:0] prod;
    idx = 0;
    case (it.operation)
      OP_ALLOC: st = track_alloc(it.address, it.alloc_size, idx);
      OP_FREE: begin
        if (find_entry(it.address, pos)) begin
          idx = pos;
          if (tbl_freed[pos]) st = ST_DOUBLE_FREE;
          else begin
            tbl_freed[pos] = 1'b1;
            st = ST_FREED;
          end
        end else begin
          idx = tbl_used;
          st = ST_NOT_FOUND;
        end
      end
      OP_REALLOC: begin
        if (it.address != it.new_address) begin
          if (find_entry(it.address, pos)) tbl_freed[pos] = 1'b1;
          st = track_alloc(it.new_address, it.alloc_size, idx);
        end else if (find_entry(it.address, pos)) begin
          tbl_size[pos] = it.alloc_size;
          idx = pos;
          st = ST_RESIZED;
        end else begin
          idx = tbl_used;
          st = ST_NOT_FOUND;
        end
      end
      default: begin
        if (find_entry(it.address, pos)) begin
          idx = pos;
          if (it.elem_index[31]) st = ST_OUT_BOUNDS;
          else begin
            prod = 48'(it.elem_size) * 48'(unsigned'(it.elem_index));
            st = (prod > 48'(tbl_size[pos])) ? ST_OUT_BOUNDS : ST_IN_BOUNDS;
          end
        end else begin
          idx = tbl_used;
          st = ST_NOT_FOUND;
        end
      end
    endcase
    r.status = st;
    r.entry_index = 11'(idx);
    r.entry_count = 11'(tbl_used);
    return r;
  endfunction

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.status !== exp_r.status || out_item.entry_index !== exp_r.entry_index ||
            out_item.entry_count !== exp_r.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", exp_r, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("allocation_tracking_table_test NOT OK");
      $finish;
    end
  end

  // Drives one item and books its prediction once the block has taken it and busy drops.
  // Start stays high on return; the caller drops it once the last item is in.
  task automatic send_item(input in_item_t it, input bit has_golden, input out_item_t golden);
    out_item_t pred;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = track_item(it);
    pending_results.push_back(pred);
    if (has_golden && pred != golden) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: expected %p, predicted %p",
                                     golden, pred);
    end
  endtask

  function automatic logic [47:0] pick_addr();
    int k;
    k = $urandom_range(9);
    if (live_addrs.size() > 0 && k < 7)
      return live_addrs[$urandom_range(live_addrs.size() - 1)];
    if (k == 7) return 48'(16 * $urandom_range(63));
    return 48'({$urandom, $urandom});
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.operation = (sel < 30) ? OP_ALLOC : (sel < 55) ? OP_FREE :
                   (sel < 75) ? OP_REALLOC : OP_BOUNDS;
    it.address = pick_addr();
    it.new_address = ($urandom_range(3) == 0) ? it.address : pick_addr();
    it.alloc_size = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(4096));
    it.elem_size = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16));
    case ($urandom_range(3))
      0: it.elem_index = $urandom;
      1: it.elem_index = -32'sd1 * $urandom_range(4);
      default: it.elem_index = $urandom_range(600);
    endcase
    return it;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        has_golden;
    out_item_t golden;
  } stim_row_t;

  localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;

  function automatic stim_row_t mk(logic [1:0] op, logic [47:0] a, logic [47:0] na,
                                   logic [31:0] sz, logic [15:0] es, logic [31:0] ei,
                                   bit g, logic [3:0] st, int idx, int cnt);
    stim_row_t r;
    r.it = '{op, a, na, sz, es, ei};
    r.has_golden = g;
    r.golden = '{st, 11'(idx), 11'(cnt)};
    return r;
  endfunction

  stim_row_t directed [$];
  in_item_t  rnd;
  int        phase_pct [4] = '{0, 79, 0, 23};

  initial begin
    mismatches = 0;
    cycles = 0;
    tbl_used = 0;
    sender_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    // Operations on an empty table, extremes of every field, and each special case.
    directed.push_back(mk(OP_FREE, 48'h0, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0));
    directed.push_back(mk(OP_BOUNDS, AMAX, 0, 0, 16'hFFFF, 32'h7FFF_FFFF,
                          1, ST_NOT_FOUND, 0, 0));
    directed.push_back(mk(OP_REALLOC, 48'h5, 48'h5, 7, 0, 0, 1, ST_NOT_FOUND, 0, 0));
    directed.push_back(mk(OP_ALLOC, 48'h0, 0, 32'hFFFF_FFFF, 0, 0, 1, ST_ADDED, 0, 1));
    directed.push_back(mk(OP_ALLOC, AMAX, 0, 100, 0, 0, 1, ST_ADDED, 1, 2));
    directed.push_back(mk(OP_ALLOC, 48'h8000_0000_0000, 0, 0, 0, 0, 1, ST_ADDED, 1, 3));
    directed.push_back(mk(OP_FREE, AMAX, 0, 0, 0, 0, 1, ST_FREED, 2, 3));
    directed.push_back(mk(OP_FREE, AMAX, 0, 0, 0, 0, 1, ST_DOUBLE_FREE, 2, 3));
    directed.push_back(mk(OP_BOUNDS, AMAX, 0, 0, 10, 10, 1, ST_IN_BOUNDS, 2, 3));
    directed.push_back(mk(OP_BOUNDS, AMAX, 0, 0, 1, 101, 1, ST_OUT_BOUNDS, 2, 3));
    directed.push_back(mk(OP_BOUNDS, AMAX, 0, 0, 0, 32'h8000_0000, 1, ST_OUT_BOUNDS, 2, 3));
    directed.push_back(mk(OP_BOUNDS, 48'h0, 0, 0, 16'hFFFF, 32'h7FFF_FFFF,
                          1, ST_OUT_BOUNDS, 0, 3));
    directed.push_back(mk(OP_BOUNDS, 48'h0, 0, 0, 16'hFFFF, 32'h0001_0001,
                          1, ST_IN_BOUNDS, 0, 3));
    directed.push_back(mk(OP_ALLOC, AMAX, 0, 5, 0, 0, 1, ST_REUSED, 2, 3));
    directed.push_back(mk(OP_REALLOC, AMAX, AMAX, 9, 0, 0, 1, ST_RESIZED, 2, 3));
    directed.push_back(mk(OP_REALLOC, 48'h0, 48'h1234, 64, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_REALLOC, 48'h777, 48'h8000_0000_0000, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_REALLOC, 48'h0, AMAX, 3, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_FREE, 48'h0, 0, 0, 0, 0, 1, ST_DOUBLE_FREE, 0, 4));
    directed.push_back(mk(OP_BOUNDS, 48'h1234, 0, 0, 16'h5555, 32'h2AAA_AAAA,
                          0, 0, 0, 0));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i].it, directed[i].has_golden,
                                    directed[i].golden);
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = phase_pct[p];
      repeat (150) begin
        rnd = rand_item();
        send_item(rnd, 0, '0);
      end
    end
    // Fill the table to its limit with ascending addresses, then hit the full case.
    sender_idle_pct = 0;
    while (tbl_used < DEPTH) begin
      rnd = '{OP_ALLOC, 48'h1_0000_0000 + 48'(tbl_used), 0, 32'(tbl_used), 0, 0};
      send_item(rnd, 0, '0);
    end
    send_item('{OP_ALLOC, 48'h3, 0, 1, 0, 0}, 1, '{ST_TABLE_FULL, 11'(DEPTH), 11'(DEPTH)});
    send_item('{OP_REALLOC, AMAX, 48'h9, 1, 0, 0}, 0, '0);
    repeat (80) begin
      rnd = rand_item();
      send_item(rnd, 0, '0);
    end
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("allocation_tracking_table_test OK");
    end else begin
      $display("allocation_tracking_table_test NOT OK");
    end
    $finish;
  end

endmodule
